>>> hw/rtl/raster_color_ramp_mapper_top_defines.svh
// ----------------------------------------------------------------------------
// Raster color ramp mapper assertion macros
// Concurrent assertion wrappers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef RASTER_COLOR_RAMP_MAPPER_TOP_DEFINES_SVH
`define RASTER_COLOR_RAMP_MAPPER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Condition holds in the same cycle.
`define RCRM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcrm assertion failed");
// Condition holds in the following cycle.
`define RCRM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcrm assertion failed");
`else
`define RCRM_ASSERT_IMP(label, ante, cons)
`define RCRM_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/rcrm_pkg.sv
// ----------------------------------------------------------------------------
// rcrm_pkg
// Types, codes and helpers shared by the color ramp mapper modules.
// ----------------------------------------------------------------------------
`default_nettype none
package rcrm_pkg;

  localparam logic [2:0] MODE_INHERIT     = 3'd0;
  localparam logic [2:0] MODE_LINEAR      = 3'd1;
  localparam logic [2:0] MODE_DISCRETE    = 3'd2;
  localparam logic [2:0] MODE_EXACT       = 3'd3;
  localparam logic [2:0] MODE_LINEAR_RGBA = 3'd4;
  localparam logic [2:0] MODE_LINEAR_BGRA = 3'd5;

  localparam logic [2:0] REG_DEFAULT_MODE  = 3'd0;
  localparam logic [2:0] REG_DEFAULT_COLOR = 3'd1;
  localparam logic [2:0] REG_NODATA_ENABLE = 3'd2;
  localparam logic [2:0] REG_NODATA_VALUE  = 3'd3;
  localparam logic [2:0] REG_NODATA_OPAQUE = 3'd4;

  localparam int          ADDR_W       = 5;
  localparam int          DIV_STEPS    = 16;
  localparam logic [31:0] OPAQUE_BLACK = 32'hff00_0000;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_NODATA,
    KIND_APPEND
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic [2:0]         mode;
    logic [31:0]        color;
  } item_t;

  typedef struct packed {
    logic [2:0]         default_mode;
    logic [31:0]        default_color;
    logic               nodata_enable;
    logic signed [31:0] nodata_value;
    logic               nodata_opaque;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         mode;
    logic [31:0]        color;
  } stop_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DIV,
    ST_MUL,
    ST_LERP,
    ST_OUT
  } state_t;

  function automatic logic [31:0] swap_rb(input logic [31:0] c);
    return {c[31:24], c[7:0], c[15:8], c[23:16]};
  endfunction

  function automatic logic is_linear(input logic [2:0] m);
    return (m == MODE_LINEAR) || (m == MODE_LINEAR_RGBA) || (m == MODE_LINEAR_BGRA);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rcrm_queue.sv
// ----------------------------------------------------------------------------
// rcrm_queue
// Two-entry item queue between the front classifier and the back engine.
// ----------------------------------------------------------------------------
`default_nettype none
module rcrm_queue
  import rcrm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire item_t   push_item,
  input  wire logic    pop,
  output item_t        head,
  output q_stat_t      stat
);

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_item;
  end

  assign head          = slots[rp];
  assign stat.full     = (cnt == 2'd2);
  assign stat.nonempty = (cnt != 2'd0);

endmodule
`default_nettype wire

>>> hw/rtl/rcrm_front.sv
// ----------------------------------------------------------------------------
// rcrm_front
// Accepts input items and sorts them into append, nodata and pixel kinds.
// ----------------------------------------------------------------------------
`default_nettype none
module rcrm_front
  import rcrm_pkg::*;
(
  input  wire logic               in_valid,
  input  wire logic               action,
  input  wire logic signed [31:0] value,
  input  wire logic [2:0]         stop_mode,
  input  wire logic [31:0]        stop_color,
  input  wire cfg_t               cfg,
  input  wire q_stat_t            q_stat,
  output logic                    in_stall,
  output logic                    push,
  output item_t                   item
);

  always_comb begin
    item.value = value;
    item.mode  = stop_mode;
    item.color = stop_color;
    if (action) begin
      item.kind = KIND_APPEND;
    end else if (cfg.nodata_enable && (value == cfg.nodata_value)) begin
      item.kind = KIND_NODATA;
    end else begin
      item.kind = KIND_PIXEL;
    end
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

endmodule
`default_nettype wire

>>> hw/rtl/rcrm_back.sv
// ----------------------------------------------------------------------------
// rcrm_back
// Stop table, segment search, fraction divider, interpolation and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "raster_color_ramp_mapper_top_defines.svh"
module rcrm_back
  import rcrm_pkg::*;
#(
  parameter int MAX_STOPS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire item_t   head,
  input  wire q_stat_t q_stat,
  output logic         pop,
  input  wire logic    out_stall,
  output logic         out_valid,
  output logic [31:0]  color,
  output logic         accepted,
  output logic         was_nodata
);

  localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CW = $clog2(MAX_STOPS + 1);

  state_t state, state_next;

  stop_t              stops [MAX_STOPS];
  stop_t              rd_q;
  stop_t              prev;
  logic [CW-1:0]      stop_count;
  logic signed [31:0] last_value;
  logic [IW-1:0]      scan_i;

  logic signed [31:0] cur_value;
  logic [31:0]        s_col;
  logic [31:0]        n_col;
  logic [2:0]         mode_q;
  logic [32:0]        rem;
  logic [32:0]        den;
  logic [15:0]        quo;
  logic [3:0]         div_cnt;
  logic [47:0]        pe;
  logic [47:0]        ps;
  logic [23:0]        cpe [4];
  logic [23:0]        cps [4];

  logic [31:0]        res_color;
  logic               res_acc;
  logic               res_nd;

  logic               wr_en;
  logic               load_out;
  logic               app_ok;
  logic               found_lt;
  logic               last_i;
  logic               below;
  logic               seg_done;
  logic signed [31:0] sel_sv;
  logic [31:0]        sel_sc;
  logic [2:0]         sel_raw;
  logic [2:0]         sel_mode;
  logic               need_div;
  logic [31:0]        direct_color;
  logic [33:0]        r2;
  logic [31:0]        ws;
  logic [31:0]        we;
  logic [48:0]        tw;
  logic [31:0]        word_res;
  logic [31:0]        chan_res;
  logic [24:0]        tc [4];

  // Segment selection once the scan has stopped on a stop.
  always_comb begin
    found_lt = (cur_value < rd_q.value);
    last_i   = (CW'(scan_i) == (stop_count - CW'(1)));
    below    = found_lt && (scan_i == '0);
    seg_done = found_lt || last_i;
    if (below) begin
      sel_sv  = cur_value;
      sel_sc  = cfg.default_color;
      sel_raw = cfg.default_mode;
    end else if (found_lt) begin
      sel_sv  = prev.value;
      sel_sc  = prev.color;
      sel_raw = prev.mode;
    end else begin
      sel_sv  = rd_q.value;
      sel_sc  = rd_q.color;
      sel_raw = rd_q.mode;
    end
    sel_mode = (!below && (sel_raw == MODE_INHERIT)) ? cfg.default_mode : sel_raw;
    need_div = is_linear(sel_mode) && (rd_q.value != sel_sv);
    if (is_linear(sel_mode) || (sel_mode == MODE_DISCRETE)) begin
      direct_color = sel_sc;
    end else begin
      direct_color = (cur_value == sel_sv) ? sel_sc : cfg.default_color;
    end
  end

  assign app_ok = (stop_count < CW'(MAX_STOPS)) &&
                  ((stop_count == '0) || (head.value > last_value));

  // Interpolation of the registered partial products.
  always_comb begin
    ws = (mode_q == MODE_LINEAR_BGRA) ? swap_rb(s_col) : s_col;
    we = (mode_q == MODE_LINEAR_BGRA) ? swap_rb(n_col) : n_col;
    r2 = {rem, 1'b0};
    tw = {1'b0, ws, 16'b0} + {1'b0, pe} - {1'b0, ps};
    word_res = (mode_q == MODE_LINEAR_BGRA) ? swap_rb(tw[47:16]) : tw[47:16];
    for (int k = 0; k < 4; k++) begin
      tc[k] = {1'b0, s_col[8*k +: 8], 16'b0} + {1'b0, cpe[k]} - {1'b0, cps[k]};
      chan_res[8*k +: 8] = tc[k][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_stat.nonempty) begin
          pop = 1'b1;
          case (head.kind)
            KIND_APPEND: begin
              wr_en      = app_ok;
              state_next = ST_OUT;
            end
            KIND_NODATA: state_next = ST_OUT;
            default:     state_next = (stop_count == '0) ? ST_OUT : ST_SCAN_RD;
          endcase
        end
      end
      ST_SCAN_RD:  state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (seg_done) begin
          state_next = need_div ? ST_DIV : ST_OUT;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_DIV: begin
        if (div_cnt == 4'(DIV_STEPS - 1)) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_LERP;
      ST_LERP: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Stop table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) stops[stop_count[IW-1:0]] <= '{head.value, head.mode, head.color};
    if (state == ST_SCAN_RD) rd_q <= stops[scan_i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= '0;
    end else if (wr_en) begin
      stop_count <= stop_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) last_value <= head.value;
    if (pop) begin
      cur_value <= head.value;
      scan_i    <= '0;
      res_nd    <= (head.kind == KIND_NODATA);
      res_acc   <= (head.kind != KIND_APPEND) || app_ok;
      case (head.kind)
        KIND_APPEND: res_color <= 32'd0;
        KIND_NODATA: res_color <= cfg.nodata_opaque ? OPAQUE_BLACK : 32'd0;
        default:     res_color <= cfg.default_color;
      endcase
    end
    if (state == ST_SCAN_CMP) begin
      if (seg_done) begin
        s_col     <= sel_sc;
        n_col     <= rd_q.color;
        mode_q    <= sel_mode;
        rem       <= {cur_value[31], cur_value} - {sel_sv[31], sel_sv};
        den       <= {rd_q.value[31], rd_q.value} - {sel_sv[31], sel_sv};
        quo       <= '0;
        div_cnt   <= '0;
        res_color <= direct_color;
      end else begin
        prev   <= rd_q;
        scan_i <= scan_i + IW'(1);
      end
    end
    // Restoring division, one quotient bit a cycle.
    if (state == ST_DIV) begin
      if (r2 >= {1'b0, den}) begin
        rem <= 33'(r2 - {1'b0, den});
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= r2[32:0];
        quo <= {quo[14:0], 1'b0};
      end
      div_cnt <= div_cnt + 4'd1;
    end
    if (state == ST_MUL) begin
      pe <= quo * we;
      ps <= quo * ws;
      for (int k = 0; k < 4; k++) begin
        cpe[k] <= quo * n_col[8*k +: 8];
        cps[k] <= quo * s_col[8*k +: 8];
      end
    end
    if (state == ST_LERP) begin
      res_color <= (mode_q == MODE_LINEAR) ? chan_res : word_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      color      <= res_color;
      accepted   <= res_acc;
      was_nodata <= res_nd;
    end
  end

  `RCRM_ASSERT_IMP(a_count_max, 1'b1, stop_count <= CW'(MAX_STOPS))
  `RCRM_ASSERT_NXT(a_count_inc, wr_en, stop_count == $past(stop_count) + CW'(1))
  `RCRM_ASSERT_IMP(a_nodata_acc, load_out && res_nd, res_acc && (res_color[23:0] == 24'd0))
  `RCRM_ASSERT_IMP(a_div_rem, state == ST_DIV, rem < den)

endmodule
`default_nettype wire

>>> hw/rtl/raster_color_ramp_mapper_top.sv
// ----------------------------------------------------------------------------
// raster_color_ramp_mapper_top
// Maps Q16.16 raster samples to packed colors through a table of stops.
//
//   Port group   Direction  Handshake          Payload
//   input        in         in_valid/in_stall  action, value, stop_mode, stop_color
//   output       out        out_valid/out_stall color, accepted, was_nodata
//   config       in/out     APB (psel/penable) paddr, pwdata, prdata
//
// Appends, nodata samples and samples with an empty table go straight from the
// queue to the output state. Other samples scan the stop table (one read port)
// with a read and a compare state per stop, then pass the bit-serial divider,
// multiply, interpolate and output states when the segment is linear with
// distinct end values, or only the output state otherwise.
// Reset is synchronous and empties the stop table and the item queue.
// A two-item queue keeps the input taking items while the engine or a
// stalled output holds; the output register frees the engine after each item.
// ----------------------------------------------------------------------------
`default_nettype none
module raster_color_ramp_mapper_top
  import rcrm_pkg::*;
#(
  parameter int MAX_STOPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic signed [31:0] value,
  input  wire logic [2:0]         stop_mode,
  input  wire logic [31:0]        stop_color,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             color,
  output logic                    accepted,
  output logic                    was_nodata,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t    cfg;
  item_t   push_item;
  item_t   head;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  logic    cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (paddr[ADDR_W-1:2])
        REG_DEFAULT_MODE:  cfg.default_mode  <= pwdata[2:0];
        REG_DEFAULT_COLOR: cfg.default_color <= pwdata;
        REG_NODATA_ENABLE: cfg.nodata_enable <= pwdata[0];
        REG_NODATA_VALUE:  cfg.nodata_value  <= pwdata;
        REG_NODATA_OPAQUE: cfg.nodata_opaque <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_DEFAULT_MODE:  prdata = {29'd0, cfg.default_mode};
      REG_DEFAULT_COLOR: prdata = cfg.default_color;
      REG_NODATA_ENABLE: prdata = {31'd0, cfg.nodata_enable};
      REG_NODATA_VALUE:  prdata = cfg.nodata_value;
      REG_NODATA_OPAQUE: prdata = {31'd0, cfg.nodata_opaque};
      default:           prdata = 32'd0;
    endcase
  end

  rcrm_front u_front (
    .in_valid   (in_valid),
    .action     (action),
    .value      (value),
    .stop_mode  (stop_mode),
    .stop_color (stop_color),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .in_stall   (in_stall),
    .push       (push),
    .item       (push_item)
  );

  rcrm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  rcrm_back #(
    .MAX_STOPS (MAX_STOPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .color      (color),
    .accepted   (accepted),
    .was_nodata (was_nodata)
  );

endmodule
`default_nettype wire

>>> bench/tb_raster_color_ramp_mapper_top.sv
// ----------------------------------------------------------------------------
// Color ramp mapper testbench
// Drives stop appends and pixel samples through the valid/stall input, checks
// every output item against an in-bench prediction of the ramp lookup, and
// walks the configuration registers through several settings between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_raster_color_ramp_mapper_top;
  import rcrm_pkg::*;

  localparam int NSTOPS = 16;
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    logic               action;
    logic signed [31:0] value;
    logic [2:0]         mode;
    logic [31:0]        color;
  } pix_item_t;

  typedef struct {
    logic [31:0] color;
    logic        accepted;
    logic        was_nodata;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic signed [31:0] value = '0;
  logic [2:0] stop_mode = '0;
  logic [31:0] stop_color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] color;
  logic accepted;
  logic was_nodata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  raster_color_ramp_mapper_top #(.MAX_STOPS(NSTOPS)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .value(value), .stop_mode(stop_mode), .stop_color(stop_color),
    .out_valid(out_valid), .out_stall(out_stall), .color(color),
    .accepted(accepted), .was_nodata(was_nodata), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state.
  logic [2:0]         m_dmode;
  logic [31:0]        m_dcolor;
  logic               m_nd_en;
  logic signed [31:0] m_nd_val;
  logic               m_nd_opq;
  logic signed [31:0] m_sval[NSTOPS];
  logic [31:0]        m_scol[NSTOPS];
  logic [2:0]         m_smode[NSTOPS];
  int                 m_count;

  pix_item_t   pending_items[$];
  pix_result_t expected_colors[$];
  int  fail_count = 0;
  bit  quiet_in = 0, quiet_out = 0, hold_in = 0;
  int  idle_cycles = 0;

  // Stall seen at the last rising edge, so the driver knows what was taken.
  logic in_stall_s = 1'b1;

  function automatic logic [31:0] blend_word(logic [31:0] s, logic [31:0] e,
                                             logic [15:0] f);
    longint t;
    t = longint'(s) * 65536 + longint'(f) * (longint'(e) - longint'(s));
    return t[47:16];
  endfunction

  function automatic logic [31:0] blend_channels(logic [31:0] s, logic [31:0] e,
                                                 logic [15:0] f);
    logic [31:0] r;
    logic [31:0] w;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      w = blend_word({24'd0, s[8*k +: 8]}, {24'd0, e[8*k +: 8]}, f);
      r[8*k +: 8] = w[7:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] flip_rb(logic [31:0] c);
    return {c[31:24], c[7:0], c[15:8], c[23:16]};
  endfunction

  function automatic logic [31:0] ramp_color(logic signed [31:0] v);
    int idx, nxt;
    bit below;
    logic [2:0] md;
    logic [31:0] sc, nc;
    longint sv, nv, q;
    logic [15:0] f;
    if (m_count == 0) return m_dcolor;
    idx = m_count - 1;
    below = 0;
    for (int i = 0; i < m_count; i++) begin
      if (v < m_sval[i]) begin
        if (i == 0) below = 1;
        else idx = i - 1;
        break;
      end
    end
    if (below) begin
      nxt = 0; md = m_dmode; sc = m_dcolor; sv = v;
    end else begin
      nxt = (idx + 1 < m_count) ? idx + 1 : m_count - 1;
      md = m_smode[idx];
      if (md == MODE_INHERIT) md = m_dmode;
      sc = m_scol[idx]; sv = m_sval[idx];
    end
    nc = m_scol[nxt]; nv = m_sval[nxt];
    f = '0;
    if (is_linear(md) && nv != sv) begin
      q = ((longint'(v) - sv) <<< 16) / (nv - sv);
      f = (q > 65535) ? 16'hffff : q[15:0];
    end
    case (md)
      MODE_LINEAR:      return (nv == sv) ? sc : blend_channels(sc, nc, f);
      MODE_LINEAR_RGBA: return (nv == sv) ? sc : blend_word(sc, nc, f);
      MODE_LINEAR_BGRA:
        return (nv == sv) ? sc : flip_rb(blend_word(flip_rb(sc), flip_rb(nc), f));
      MODE_DISCRETE:    return sc;
      default:          return (longint'(v) == sv) ? sc : m_dcolor;
    endcase
  endfunction

  function automatic pix_result_t predict_item(pix_item_t it);
    pix_result_t r;
    r.color = '0; r.accepted = 1'b1; r.was_nodata = 1'b0;
    if (it.action) begin
      if (m_count >= NSTOPS || (m_count > 0 && it.value <= m_sval[m_count-1])) begin
        r.accepted = 1'b0;
      end else begin
        m_sval[m_count] = it.value; m_smode[m_count] = it.mode;
        m_scol[m_count] = it.color; m_count++;
      end
    end else if (m_nd_en && it.value == m_nd_val) begin
      r.color = m_nd_opq ? OPAQUE_BLACK : 32'd0;
      r.was_nodata = 1'b1;
    end else begin
      r.color = ramp_color(it.value);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  // Driver: presents the head of the pending queue at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_s) begin
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall_s) begin
        // hold the stalled item unchanged
      end else if (pending_items.size() > 0 && !hold_in &&
                   (quiet_in || $urandom_range(0, 99) >= 18)) begin
        in_valid   <= 1'b1;
        action     <= pending_items[0].action;
        value      <= pending_items[0].value;
        stop_mode  <= pending_items[0].mode;
        stop_color <= pending_items[0].color;
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= quiet_out ? 1'b0 : ($urandom_range(0, 99) < 18);
    end
  end

  // Monitor: predicts at input acceptance and checks at output acceptance.
  always @(posedge clk) begin
    pix_item_t it;
    pix_result_t exp_r;
    in_stall_s <= in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        it.action = action; it.value = value; it.mode = stop_mode; it.color = stop_color;
        expected_colors.insert(expected_colors.size(), predict_item(it));
      end
      if (out_valid && !out_stall) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("unexpected item", color, 32'd0);
        end else begin
          exp_r = expected_colors.pop_front();
          if (color !== exp_r.color) report_mismatch("color", color, exp_r.color);
          if (accepted !== exp_r.accepted)
            report_mismatch("accepted", {31'd0, accepted}, {31'd0, exp_r.accepted});
          if (was_nodata !== exp_r.was_nodata)
            report_mismatch("was_nodata", {31'd0, was_nodata}, {31'd0, exp_r.was_nodata});
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_DEFAULT_MODE:  m_dmode = data[2:0];
      REG_DEFAULT_COLOR: m_dcolor = data;
      REG_NODATA_ENABLE: m_nd_en = data[0];
      REG_NODATA_VALUE:  m_nd_val = data;
      default:           m_nd_opq = data[0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_colors.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic push_item(logic act, logic signed [31:0] v, logic [2:0] md,
                           logic [31:0] c);
    pix_item_t it;
    it.action = act; it.value = v; it.mode = md; it.color = c;
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic signed [31:0] rand_word();
    return $urandom();
  endfunction

  // Each phase empties the table by reset-free means is impossible, so the
  // table fills once; samples keep probing it under varying configuration.
  initial begin
    logic signed [31:0] base;
    int step;
    m_dmode = MODE_INHERIT; m_dcolor = '0; m_nd_en = 0; m_nd_val = '0; m_nd_opq = 0;
    m_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Empty table, then defaults, then extremes.
    reg_write(REG_DEFAULT_COLOR, 32'h8040_2010);
    reg_write(REG_NODATA_ENABLE, 32'd1);
    reg_write(REG_NODATA_VALUE, 32'h8000_0000);
    reg_write(REG_NODATA_OPAQUE, 32'd1);
    reg_write(REG_DEFAULT_MODE, {29'd0, MODE_LINEAR});
    push_item(0, 32'sh7fff_ffff, MODE_INHERIT, '0);
    push_item(0, 32'sh8000_0000, MODE_INHERIT, '0);
    push_item(0, 32'sh0000_0000, MODE_INHERIT, '0);
    // Stops: every mode, including unused codes, one rejected out of order.
    push_item(1, -32'sd1000000, MODE_LINEAR, 32'h0000_00ff);
    push_item(1, -32'sd1000000, MODE_DISCRETE, 32'hffff_ffff);
    push_item(1, -32'sd500000, MODE_LINEAR_RGBA, 32'hff00_ff00);
    push_item(1, 32'sd0, MODE_LINEAR_BGRA, 32'h00ff_00ff);
    push_item(1, 32'sd65536, MODE_DISCRETE, 32'h1234_5678);
    push_item(1, 32'sd131072, MODE_EXACT, 32'habcd_ef01);
    push_item(1, 32'sd200000, MODE_INHERIT, 32'h5555_aaaa);
    push_item(1, 32'sd300000, 3'd6, 32'hdead_beef);
    push_item(1, 32'sd400000, 3'd7, 32'h0f0f_f0f0);
    push_item(0, -32'sd2000000, MODE_INHERIT, '0);
    push_item(0, -32'sd750000, MODE_INHERIT, '0);
    push_item(0, -32'sd100, MODE_INHERIT, '0);
    push_item(0, 32'sd131072, MODE_INHERIT, '0);
    push_item(0, 32'sd131073, MODE_INHERIT, '0);
    push_item(0, 32'sd250000, MODE_INHERIT, '0);
    push_item(0, 32'sd400000, MODE_INHERIT, '0);
    push_item(0, 32'sh7fff_ffff, MODE_INHERIT, '0);
    push_item(0, 32'sh8000_0000, MODE_INHERIT, '0);
    wait_drained();

    // Random: append further stops among samples swept under many settings.
    base = 32'sd500000;
    for (int ph = 0; ph < 10; ph++) begin
      reg_write(REG_DEFAULT_MODE, (ph == 9) ? 32'd0 : $urandom_range(0, 7));
      reg_write(REG_DEFAULT_COLOR, (ph == 1) ? 32'hffff_ffff : $urandom());
      reg_write(REG_NODATA_ENABLE, ph % 2);
      reg_write(REG_NODATA_VALUE, (ph == 3) ? 32'h7fff_ffff : $urandom_range(0, 400000));
      reg_write(REG_NODATA_OPAQUE, (ph / 2) % 2);
      quiet_in = (ph == 4); quiet_out = (ph == 4);
      for (int k = 0; k < 200; k++) begin
        if (k % 50 == 0 && $urandom_range(0, 3) == 0) begin
          step = $urandom_range(1, 200000);
          push_item(1, ($urandom_range(0, 5) == 0) ? rand_word() : base + step,
                    $urandom_range(0, 7), $urandom());
          base = base + step;
        end else begin
          case ($urandom_range(0, 4))
            0: push_item(0, rand_word(), $urandom_range(0, 7), $urandom());
            1: push_item(0, m_nd_val, $urandom_range(0, 7), $urandom());
            2: push_item(0, (m_count > 0) ? m_sval[$urandom_range(0, m_count-1)]
                                          : rand_word(), $urandom_range(0, 7), $urandom());
            default: push_item(0, $urandom_range(0, 2000000) - 1000000,
                               $urandom_range(0, 7), $urandom());
          endcase
        end
        if (ph == 5 && k == 100) begin
          // The sender pauses with items still pending until all results are in.
          hold_in = 1;
          while (in_valid || expected_colors.size() > 0) @(posedge clk);
          hold_in = 0;
        end
      end
      wait_drained();
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> raster_color_ramp_mapper_top.f
+incdir+hw/rtl
hw/rtl/rcrm_pkg.sv
hw/rtl/rcrm_queue.sv
hw/rtl/rcrm_front.sv
hw/rtl/rcrm_back.sv
hw/rtl/raster_color_ramp_mapper_top.sv
bench/tb_raster_color_ramp_mapper_top.sv
